// ===== hw/rtl/bcvf_pkg.sv =====
// Shared types and codes for the bridge and cut vertex finder.
package bcvf_pkg;

   // Width of every vertex field on the ports
   localparam int unsigned FIELD_W = 6;

   // Command codes
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_RUN   = 2'd1;
   localparam logic [1:0] FUNC_CLEAR = 2'd2;

   // Result kinds
   localparam logic [2:0] KIND_ACCEPT = 3'd0;
   localparam logic [2:0] KIND_REJECT = 3'd1;
   localparam logic [2:0] KIND_BRIDGE = 3'd2;
   localparam logic [2:0] KIND_CUT    = 3'd3;
   localparam logic [2:0] KIND_DONE   = 3'd4;
   localparam logic [2:0] KIND_CLEAR  = 3'd5;

   // Bridge and cut words per run, before the done word
   localparam logic [5:0] RESULT_LIMIT = 6'd61;

   // Vertex count register after reset
   localparam logic [5:0] VC_RESET = 6'd32;

   typedef struct packed {
      logic [1:0]         func;
      logic [FIELD_W-1:0] vertex_a;
      logic [FIELD_W-1:0] vertex_b;
   } req_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [FIELD_W-1:0] first_vertex;
      logic [FIELD_W-1:0] second_vertex;
      logic               last;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_ADD_RD,
      ST_ADD_WR,
      ST_CLR_SWEEP,
      ST_ROOT_RD,
      ST_ROOT_CHK,
      ST_PUSH_SAVE,
      ST_PUSH,
      ST_PUSH_LOAD,
      ST_STEP,
      ST_EDGE,
      ST_VCHK,
      ST_POP_VX,
      ST_POP_DONE,
      ST_CUT_SCAN,
      ST_DONE
   } state_type;

endpackage

// ===== hw/rtl/bridge_and_cut_vertex_finder_unit.sv =====
// Top level: bridge and cut vertex finder with edge store and search sequencer.
//
// Usage:
//   Commands enter on req_data when start is high and busy is low. An add
//   command appends an undirected edge to the adjacency store, a run command
//   performs a depth-first search over vertices 1..vertex_count, a clear
//   command empties every adjacency list. Each result word shows on rsp_data
//   for one cycle with rsp_valid high; the final word of a command has last
//   set. The receiver cannot stall: words are dropped onto the port as made.
//   csr_wr_en writes vertex_count; write it only while busy is low.
//   A rejected add or a clear answers in the cycle after acceptance
//   with busy staying low; an accepted add keeps busy high through the
//   ADD_RD and ADD_WR states once per direction and answers in the cycle
//   after. A run's time grows with N active vertices, V reached vertices
//   and E adjacency entries visited, since the vertex state memory and the
//   adjacency memories each have one read port with a registered read.
//   Func code 3 is ignored.
//   Reset empties all lists and sets vertex_count to 32. Per-run vertex state
//   is swept to zero vertex by vertex at the start of every run.
module bridge_and_cut_vertex_finder_unit #(
   parameter int unsigned MAX_VERTICES = 32,
   parameter int unsigned MAX_EDGES    = 128
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  bcvf_pkg::req_type req_data,
   output logic              rsp_valid,
   output bcvf_pkg::rsp_type rsp_data,
   input  logic              csr_wr_en,
   input  logic [5:0]        csr_wr_data
);
   localparam int unsigned VW          = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int unsigned CW          = VW + 1;
   localparam int unsigned TW          = CW;
   localparam int unsigned NUM_ENTRIES = 2 * MAX_EDGES;
   localparam int unsigned EW          = $clog2(NUM_ENTRIES);
   localparam int unsigned NW          = EW + 1;

   typedef struct packed {
      logic [TW-1:0] disc;
      logic [TW-1:0] low;
      logic [VW-1:0] par;
      logic          par_ok;
   } vx_type;

   typedef struct packed {
      logic [VW-1:0] vert;
      logic [EW-1:0] cur;
      logic [EW-1:0] tail;
      logic          more;
   } stk_type;

   typedef struct packed {
      logic [EW-1:0] head;
      logic [EW-1:0] tail;
   } lst_type;

   // Control and data registers
   bcvf_pkg::state_type state_ff, state_in;
   logic [5:0]              csr_ff;
   logic [MAX_VERTICES-1:0] hv_ff, hv_in;
   logic [MAX_VERTICES-1:0] cut_ff, cut_in;
   logic [NW-1:0]           cnt_ff, cnt_in;
   logic [VW-1:0]           va_ff, va_in, vb_ff, vb_in;
   logic                    side_ff, side_in;
   logic [CW-1:0]           r_ff, r_in, i_ff, i_in, sp_ff, sp_in;
   logic [VW-1:0]           u_ff, u_in, v_ff, v_in, paru_ff, paru_in;
   logic                    parvu_ff, parvu_in, more_ff, more_in;
   logic [EW-1:0]           cur_ff, cur_in, tail_ff, tail_in;
   logic [TW-1:0]           discu_ff, discu_in, lowu_ff, lowu_in, time_ff, time_in;
   logic [1:0]              rootch_ff, rootch_in;
   logic [5:0]              n_ff, n_in;
   stk_type                 pop_ff, pop_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   bcvf_pkg::rsp_type       rsp_ff, rsp_in;

   // Memory ports
   logic          nb_we, nx_we, ls_we, vx_we, st_we;
   logic [EW-1:0] nb_wa, nx_wa, adj_ra;
   logic [VW-1:0] nb_wd, nb_rd;
   logic [EW-1:0] nx_wd, nx_rd;
   logic [VW-1:0] ls_wa, ls_ra, vx_wa, vx_ra, st_wa, st_ra;
   lst_type       ls_wd, ls_rd;
   vx_type        vx_wd, vx_rd;
   stk_type       st_wd, st_rd;

   logic [CW-1:0] vc;
   logic          add_bad;
   logic [VW-1:0] add_u, add_v;

   // Clamp the vertex count register
   always_comb begin
      if (csr_ff == 6'd0) begin
         vc = CW'(1);
      end else if (csr_ff > 6'(MAX_VERTICES)) begin
         vc = CW'(MAX_VERTICES);
      end else begin
         vc = CW'(csr_ff);
      end
   end

   assign add_bad = (req_data.vertex_a == 6'd0) || (req_data.vertex_b == 6'd0) ||
                    (req_data.vertex_a > 6'(vc)) || (req_data.vertex_b > 6'(vc)) ||
                    (({1'b0, cnt_ff} + (NW+1)'(2)) > (NW+1)'(NUM_ENTRIES));
   assign add_u   = side_ff ? vb_ff : va_ff;
   assign add_v   = side_ff ? va_ff : vb_ff;

   bcvf_ram #(.WIDTH(VW), .DEPTH(NUM_ENTRIES)) u_nb_ram (
      .clock(clock), .wr_en(nb_we), .wr_addr(nb_wa), .wr_data(nb_wd),
      .rd_addr(adj_ra), .rd_data(nb_rd)
   );
   bcvf_ram #(.WIDTH(EW), .DEPTH(NUM_ENTRIES)) u_nx_ram (
      .clock(clock), .wr_en(nx_we), .wr_addr(nx_wa), .wr_data(nx_wd),
      .rd_addr(adj_ra), .rd_data(nx_rd)
   );
   bcvf_ram #(.WIDTH($bits(lst_type)), .DEPTH(MAX_VERTICES)) u_ls_ram (
      .clock(clock), .wr_en(ls_we), .wr_addr(ls_wa), .wr_data(ls_wd),
      .rd_addr(ls_ra), .rd_data(ls_rd)
   );
   bcvf_ram #(.WIDTH($bits(vx_type)), .DEPTH(MAX_VERTICES)) u_vx_ram (
      .clock(clock), .wr_en(vx_we), .wr_addr(vx_wa), .wr_data(vx_wd),
      .rd_addr(vx_ra), .rd_data(vx_rd)
   );
   bcvf_ram #(.WIDTH($bits(stk_type)), .DEPTH(MAX_VERTICES)) u_st_ram (
      .clock(clock), .wr_en(st_we), .wr_addr(st_wa), .wr_data(st_wd),
      .rd_addr(st_ra), .rd_data(st_rd)
   );

   // Hold state and data
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bcvf_pkg::ST_IDLE;
         csr_ff       <= bcvf_pkg::VC_RESET;
         hv_ff        <= '0;
         cut_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         sp_ff        <= '0;
         n_ff         <= '0;
         time_ff      <= '0;
         rootch_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         hv_ff        <= hv_in;
         cut_ff       <= cut_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         sp_ff        <= sp_in;
         n_ff         <= n_in;
         time_ff      <= time_in;
         rootch_ff    <= rootch_in;
      end
      va_ff    <= va_in;
      vb_ff    <= vb_in;
      side_ff  <= side_in;
      r_ff     <= r_in;
      i_ff     <= i_in;
      u_ff     <= u_in;
      v_ff     <= v_in;
      paru_ff  <= paru_in;
      parvu_ff <= parvu_in;
      more_ff  <= more_in;
      cur_ff   <= cur_in;
      tail_ff  <= tail_in;
      discu_ff <= discu_in;
      lowu_ff  <= lowu_in;
      pop_ff   <= pop_in;
      rsp_ff   <= rsp_in;
   end

   // Next state, memory control and result words
   always_comb begin
      state_in     = state_ff;
      hv_in        = hv_ff;
      cut_in       = cut_ff;
      cnt_in       = cnt_ff;
      va_in        = va_ff;
      vb_in        = vb_ff;
      side_in      = side_ff;
      r_in         = r_ff;
      i_in         = i_ff;
      sp_in        = sp_ff;
      u_in         = u_ff;
      v_in         = v_ff;
      paru_in      = paru_ff;
      parvu_in     = parvu_ff;
      more_in      = more_ff;
      cur_in       = cur_ff;
      tail_in      = tail_ff;
      discu_in     = discu_ff;
      lowu_in      = lowu_ff;
      time_in      = time_ff;
      rootch_in    = rootch_ff;
      n_in         = n_ff;
      pop_in       = pop_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;

      nb_we  = 1'b0;
      nb_wa  = '0;
      nb_wd  = '0;
      nx_we  = 1'b0;
      nx_wa  = '0;
      nx_wd  = '0;
      adj_ra = cur_ff;
      ls_we  = 1'b0;
      ls_wa  = add_u;
      ls_wd  = '0;
      ls_ra  = add_u;
      vx_we  = 1'b0;
      vx_wa  = u_ff;
      vx_wd  = '0;
      vx_ra  = v_ff;
      st_we  = 1'b0;
      st_wa  = '0;
      st_wd  = '0;
      st_ra  = '0;

      case (state_ff)
         bcvf_pkg::ST_IDLE: begin
            if (start) begin
               case (req_data.func)
                  bcvf_pkg::FUNC_ADD: begin
                     if (add_bad) begin
                        rsp_valid_in = 1'b1;
                        rsp_in.kind  = bcvf_pkg::KIND_REJECT;
                        rsp_in.last  = 1'b1;
                     end else begin
                        va_in    = VW'(req_data.vertex_a - 6'd1);
                        vb_in    = VW'(req_data.vertex_b - 6'd1);
                        side_in  = 1'b0;
                        state_in = bcvf_pkg::ST_ADD_RD;
                     end
                  end
                  bcvf_pkg::FUNC_RUN: begin
                     cut_in   = '0;
                     time_in  = '0;
                     n_in     = '0;
                     sp_in    = '0;
                     i_in     = '0;
                     state_in = bcvf_pkg::ST_CLR_SWEEP;
                  end
                  bcvf_pkg::FUNC_CLEAR: begin
                     hv_in        = '0;
                     cnt_in       = '0;
                     rsp_valid_in = 1'b1;
                     rsp_in.kind  = bcvf_pkg::KIND_CLEAR;
                     rsp_in.last  = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Fetch the list head and tail of the source vertex
         bcvf_pkg::ST_ADD_RD: begin
            ls_ra    = add_u;
            state_in = bcvf_pkg::ST_ADD_WR;
         end

         // Append one entry and link it behind the old tail, or start a new list
         bcvf_pkg::ST_ADD_WR: begin
            nb_we = 1'b1;
            nb_wa = cnt_ff[EW-1:0];
            nb_wd = add_v;
            ls_we = 1'b1;
            ls_wa = add_u;
            if (hv_ff[add_u]) begin
               nx_we = 1'b1;
               nx_wa = ls_rd.tail;
               nx_wd = cnt_ff[EW-1:0];
               ls_wd = '{head: ls_rd.head, tail: cnt_ff[EW-1:0]};
            end else begin
               ls_wd = '{head: cnt_ff[EW-1:0], tail: cnt_ff[EW-1:0]};
            end
            hv_in[add_u] = 1'b1;
            cnt_in       = cnt_ff + NW'(1);
            if (!side_ff) begin
               side_in  = 1'b1;
               state_in = bcvf_pkg::ST_ADD_RD;
            end else begin
               rsp_valid_in = 1'b1;
               rsp_in.kind  = bcvf_pkg::KIND_ACCEPT;
               rsp_in.last  = 1'b1;
               state_in     = bcvf_pkg::ST_IDLE;
            end
         end

         // Clear per-vertex search state
         bcvf_pkg::ST_CLR_SWEEP: begin
            if (i_ff == vc) begin
               r_in     = '0;
               state_in = bcvf_pkg::ST_ROOT_RD;
            end else begin
               vx_we = 1'b1;
               vx_wa = i_ff[VW-1:0];
               vx_wd = '0;
               i_in  = i_ff + CW'(1);
            end
         end

         // Look for the next undiscovered root
         bcvf_pkg::ST_ROOT_RD: begin
            if (r_ff == vc) begin
               i_in     = '0;
               state_in = bcvf_pkg::ST_CUT_SCAN;
            end else begin
               vx_ra    = r_ff[VW-1:0];
               state_in = bcvf_pkg::ST_ROOT_CHK;
            end
         end

         bcvf_pkg::ST_ROOT_CHK: begin
            if (vx_rd.disc != '0) begin
               r_in     = r_ff + CW'(1);
               state_in = bcvf_pkg::ST_ROOT_RD;
            end else begin
               rootch_in = '0;
               v_in      = r_ff[VW-1:0];
               state_in  = bcvf_pkg::ST_PUSH;
            end
         end

         // Spill the current top to the stack and vertex memories
         bcvf_pkg::ST_PUSH_SAVE: begin
            st_we    = 1'b1;
            st_wa    = VW'(sp_ff - CW'(1));
            st_wd    = '{vert: u_ff, cur: cur_ff, tail: tail_ff, more: more_ff};
            vx_we    = 1'b1;
            vx_wa    = u_ff;
            vx_wd    = '{disc: discu_ff, low: lowu_ff, par: paru_ff, par_ok: parvu_ff};
            state_in = bcvf_pkg::ST_PUSH;
         end

         // Stamp the new vertex and fetch its list
         bcvf_pkg::ST_PUSH: begin
            time_in  = time_ff + TW'(1);
            vx_we    = 1'b1;
            vx_wa    = v_ff;
            vx_wd    = '{disc: time_ff + TW'(1), low: time_ff + TW'(1), par: u_ff,
                         par_ok: (sp_ff != '0)};
            ls_ra    = v_ff;
            state_in = bcvf_pkg::ST_PUSH_LOAD;
         end

         bcvf_pkg::ST_PUSH_LOAD: begin
            u_in     = v_ff;
            cur_in   = ls_rd.head;
            tail_in  = ls_rd.tail;
            more_in  = hv_ff[v_ff];
            discu_in = time_ff;
            lowu_in  = time_ff;
            paru_in  = u_ff;
            parvu_in = (sp_ff != '0);
            sp_in    = sp_ff + CW'(1);
            state_in = bcvf_pkg::ST_STEP;
         end

         // Advance along the top vertex's list, or pop it, or finish the root when the stack is empty
         bcvf_pkg::ST_STEP: begin
            if (sp_ff == '0) begin
               cut_in[r_ff[VW-1:0]] = (rootch_ff == 2'd2);
               r_in     = r_ff + CW'(1);
               state_in = bcvf_pkg::ST_ROOT_RD;
            end else if (more_ff) begin
               adj_ra = cur_ff;
               if (cur_ff == tail_ff) begin
                  more_in = 1'b0;
               end
               state_in = bcvf_pkg::ST_EDGE;
            end else if (sp_ff == CW'(1)) begin
               sp_in = '0;
            end else begin
               st_ra    = VW'(sp_ff - CW'(2));
               state_in = bcvf_pkg::ST_POP_VX;
            end
         end

         bcvf_pkg::ST_EDGE: begin
            cur_in = nx_rd;
            v_in   = nb_rd;
            if (CW'(nb_rd) >= vc) begin
               state_in = bcvf_pkg::ST_STEP;
            end else begin
               vx_ra    = nb_rd;
               state_in = bcvf_pkg::ST_VCHK;
            end
         end

         // Tree edge or back edge
         bcvf_pkg::ST_VCHK: begin
            if (vx_rd.disc == '0) begin
               if ((CW'(u_ff) == r_ff) && (rootch_ff != 2'd2)) begin
                  rootch_in = rootch_ff + 2'd1;
               end
               state_in = bcvf_pkg::ST_PUSH_SAVE;
            end else begin
               if (!(parvu_ff && (paru_ff == v_ff)) && (vx_rd.disc < lowu_ff)) begin
                  lowu_in = vx_rd.disc;
               end
               state_in = bcvf_pkg::ST_STEP;
            end
         end

         bcvf_pkg::ST_POP_VX: begin
            pop_in   = st_rd;
            vx_ra    = st_rd.vert;
            state_in = bcvf_pkg::ST_POP_DONE;
         end

         // Fold the finished child into its parent, marking cut vertices and reporting bridges
         bcvf_pkg::ST_POP_DONE: begin
            if ((CW'(pop_ff.vert) != r_ff) && (lowu_ff >= vx_rd.disc)) begin
               cut_in[pop_ff.vert] = 1'b1;
            end
            if ((lowu_ff > vx_rd.disc) && (n_ff < bcvf_pkg::RESULT_LIMIT)) begin
               rsp_valid_in         = 1'b1;
               rsp_in.kind          = bcvf_pkg::KIND_BRIDGE;
               rsp_in.first_vertex  = 6'(pop_ff.vert) + 6'd1;
               rsp_in.second_vertex = 6'(u_ff) + 6'd1;
               n_in                 = n_ff + 6'd1;
            end
            u_in     = pop_ff.vert;
            cur_in   = pop_ff.cur;
            tail_in  = pop_ff.tail;
            more_in  = pop_ff.more;
            discu_in = vx_rd.disc;
            lowu_in  = (lowu_ff < vx_rd.low) ? lowu_ff : vx_rd.low;
            paru_in  = vx_rd.par;
            parvu_in = vx_rd.par_ok;
            sp_in    = sp_ff - CW'(1);
            state_in = bcvf_pkg::ST_STEP;
         end

         // Report cut vertices in ascending order
         bcvf_pkg::ST_CUT_SCAN: begin
            if (i_ff == vc) begin
               state_in = bcvf_pkg::ST_DONE;
            end else begin
               if (cut_ff[i_ff[VW-1:0]] && (n_ff < bcvf_pkg::RESULT_LIMIT)) begin
                  rsp_valid_in        = 1'b1;
                  rsp_in.kind         = bcvf_pkg::KIND_CUT;
                  rsp_in.first_vertex = 6'(i_ff) + 6'd1;
                  n_in                = n_ff + 6'd1;
               end
               i_in = i_ff + CW'(1);
            end
         end

         bcvf_pkg::ST_DONE: begin
            rsp_valid_in = 1'b1;
            rsp_in.kind  = bcvf_pkg::KIND_DONE;
            rsp_in.last  = 1'b1;
            state_in     = bcvf_pkg::ST_IDLE;
         end

         default: begin
            state_in = bcvf_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy      = (state_ff != bcvf_pkg::ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Stack depth never exceeds MAX_VERTICES
   a_sp_bound: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= CW'(MAX_VERTICES))
      else $error("search stack overflow");

   // The closing word of a command leaves the sequencer idle
   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last |-> state_ff == bcvf_pkg::ST_IDLE)
      else $error("last word while sequencer active");

   // A run command makes the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && (req_data.func == bcvf_pkg::FUNC_RUN) |=> busy)
      else $error("run not started");

   // Entries are stored in pairs and stay within the store
   a_cnt_even: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff[0] == 1'b0 || state_ff == bcvf_pkg::ST_ADD_RD ||
       state_ff == bcvf_pkg::ST_ADD_WR) &&
      cnt_ff <= NW'(NUM_ENTRIES))
      else $error("entry count corrupt");

endmodule

// ===== hw/rtl/bcvf_ram.sv =====
// Generic single-port-write, registered-read RAM.
module bcvf_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  logic                                          clock,
   input  logic                                          wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  wr_addr,
   input  logic [WIDTH-1:0]                              wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  rd_addr,
   output logic [WIDTH-1:0]                              rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write one word, read one word through a register
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
